// ===== rtl/ets_pkg.sv =====
// Shared types, widths and codes for the edge transmission state table.
// Used by ets_rules and edge_transmission_state_table_unit; depends on nothing.
package ets_pkg;

   // Network size; node fields are six bits wide.
   localparam int NODE_COUNT = 64;
   localparam int NODE_W     = 6;
   localparam int NODE_AW    = $clog2(NODE_COUNT);

   localparam int KIND_W = 3;
   localparam int ACT_W  = 3;
   localparam int ERR_W  = 3;
   localparam int MARK_W = 2;
   localparam int ROW_W  = NODE_COUNT * MARK_W;

   // Event kinds
   localparam logic [KIND_W-1:0] KIND_EDGE_ADD    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_EDGE_REMOVE = 3'd1;
   localparam logic [KIND_W-1:0] KIND_CONTACT     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_INFECT      = 3'd3;
   localparam logic [KIND_W-1:0] KIND_OUTSIDE     = 3'd4;
   localparam logic [KIND_W-1:0] KIND_RECOVER     = 3'd5;

   // Edge marks
   localparam logic [MARK_W-1:0] MARK_ADMISSIBLE  = 2'd0;
   localparam logic [MARK_W-1:0] MARK_MASKED      = 2'd1;
   localparam logic [MARK_W-1:0] MARK_TRANSMITTED = 2'd2;

   // Actions
   localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
   localparam logic [ACT_W-1:0] ACT_ACTIVATE = 3'd1;
   localparam logic [ACT_W-1:0] ACT_CONTACT  = 3'd2;
   localparam logic [ACT_W-1:0] ACT_ACCEPT   = 3'd3;
   localparam logic [ACT_W-1:0] ACT_BLOCK    = 3'd4;
   localparam logic [ACT_W-1:0] ACT_RECORD   = 3'd5;

   // Error codes
   localparam logic [ERR_W-1:0] ERR_OK           = 3'd0;
   localparam logic [ERR_W-1:0] ERR_DUP_REMOVE   = 3'd1;
   localparam logic [ERR_W-1:0] ERR_NOT_INFECTED = 3'd2;
   localparam logic [ERR_W-1:0] ERR_TRANSMITTED  = 3'd3;
   localparam logic [ERR_W-1:0] ERR_HEALTHY      = 3'd4;

   // Decision for one event: result fields plus the state updates to apply.
   typedef struct packed {
      logic [ACT_W-1:0]  action;
      logic [ERR_W-1:0]  error_code;
      logic              mark_we;
      logic [MARK_W-1:0] mark_val;
      logic              row_clear;
      logic              inf_we;
      logic              inf_val;
   } upd_type;

endpackage

// ===== rtl/ets_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ets_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ets_rules.sv =====
// Event rules: decide action, error code and state updates for one event.
// Depends on ets_pkg.
module ets_rules (
   input  logic [ets_pkg::KIND_W-1:0] kind,
   input  logic [ets_pkg::NODE_W-1:0] src_node,
   input  logic [ets_pkg::NODE_W-1:0] dst_node,
   input  logic                       src_infected,
   input  logic [ets_pkg::MARK_W-1:0] mark,
   output ets_pkg::upd_type           upd
);

   logic uses_src;
   logic src_ok;
   logic dst_ok;
   logic event_ok;
   logic admissible;
   logic masked;

   assign uses_src   = (kind == ets_pkg::KIND_EDGE_ADD) || (kind == ets_pkg::KIND_EDGE_REMOVE) ||
                       (kind == ets_pkg::KIND_CONTACT)  || (kind == ets_pkg::KIND_INFECT);
   assign src_ok     = 32'(src_node) < 32'(ets_pkg::NODE_COUNT);
   assign dst_ok     = 32'(dst_node) < 32'(ets_pkg::NODE_COUNT);
   assign event_ok   = dst_ok && (!uses_src || src_ok);
   assign admissible = (mark == ets_pkg::MARK_ADMISSIBLE);
   assign masked     = (mark == ets_pkg::MARK_MASKED);

   always_comb begin
      upd            = '0;
      upd.action     = ets_pkg::ACT_NONE;
      upd.error_code = ets_pkg::ERR_OK;
      upd.mark_val   = ets_pkg::MARK_ADMISSIBLE;
      if (event_ok) begin
         unique case (kind)
            ets_pkg::KIND_EDGE_ADD: begin
               upd.action = ets_pkg::ACT_RECORD;
               priority if (src_infected && admissible) begin
                  upd.action = ets_pkg::ACT_ACTIVATE;
               end else if (src_infected && masked) begin
                  upd.mark_we  = 1'b1;
                  upd.mark_val = ets_pkg::MARK_ADMISSIBLE;
               end else begin
                  upd.mark_we = 1'b0;
               end
            end
            ets_pkg::KIND_EDGE_REMOVE: begin
               upd.action = ets_pkg::ACT_RECORD;
               priority if (src_infected && admissible) begin
                  upd.mark_we  = 1'b1;
                  upd.mark_val = ets_pkg::MARK_MASKED;
               end else if (src_infected && masked) begin
                  upd.action     = ets_pkg::ACT_NONE;
                  upd.error_code = ets_pkg::ERR_DUP_REMOVE;
               end else begin
                  upd.mark_we = 1'b0;
               end
            end
            ets_pkg::KIND_CONTACT: begin
               upd.action = (src_infected && admissible) ? ets_pkg::ACT_CONTACT
                                                         : ets_pkg::ACT_RECORD;
            end
            ets_pkg::KIND_INFECT: begin
               priority if (!src_infected) begin
                  upd.error_code = ets_pkg::ERR_NOT_INFECTED;
               end else if (admissible) begin
                  upd.mark_we  = 1'b1;
                  upd.mark_val = ets_pkg::MARK_TRANSMITTED;
                  upd.inf_we   = 1'b1;
                  upd.inf_val  = 1'b1;
                  upd.action   = ets_pkg::ACT_ACCEPT;
               end else if (masked) begin
                  upd.mark_we  = 1'b1;
                  upd.mark_val = ets_pkg::MARK_ADMISSIBLE;
                  upd.action   = ets_pkg::ACT_BLOCK;
               end else begin
                  upd.error_code = ets_pkg::ERR_TRANSMITTED;
               end
            end
            ets_pkg::KIND_OUTSIDE: begin
               upd.inf_we  = 1'b1;
               upd.inf_val = 1'b1;
               upd.action  = ets_pkg::ACT_ACCEPT;
            end
            ets_pkg::KIND_RECOVER: begin
               // src_infected carries the target's flag for a recovery
               if (!src_infected) begin
                  upd.error_code = ets_pkg::ERR_HEALTHY;
               end else begin
                  upd.row_clear = 1'b1;
                  upd.inf_we    = 1'b1;
                  upd.inf_val   = 1'b0;
                  upd.action    = ets_pkg::ACT_RECORD;
               end
            end
            default: begin
               upd.action = ets_pkg::ACT_NONE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/edge_transmission_state_table_unit.sv =====
// Edge transmission state table, top level.
// Depends on ets_pkg, ets_ram and ets_rules.
//
// Usage
//   Request channel (req_*): one event per transaction, made of kind, source node and
//   target node. Response channel (rsp_*): exactly one action and error code per event,
//   in request order. A transaction completes at a rising edge with valid high and
//   stall low.
//   Timing: when an event is accepted, its node flag and edge row are read from memory on the
//   same edge; the execute state then applies the rules, writes back the memories that the
//   update names and loads the response register once that register is free. A new event
//   is not taken until the previous one has left the execute state, since the registered
//   read of the row memory is followed by its write-back.
//   The row memory holds one word of marks per source node, so a recovery clears its whole
//   row with a single write and costs no more than any other event.
//   Reset: clears per-row and per-node valid flags, so every mark reads as
//   admissible and every node as healthy right away; there is no clearing pass.
//   Receiver stall: the response register holds; an event already accepted waits in the
//   execute stage without writing memory until the register frees up, and req_stall stays
//   high meanwhile.
module edge_transmission_state_table_unit (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [ets_pkg::KIND_W-1:0] req_kind,
   input  logic [ets_pkg::NODE_W-1:0] req_src_node,
   input  logic [ets_pkg::NODE_W-1:0] req_dst_node,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [ets_pkg::ACT_W-1:0]  rsp_action,
   output logic [ets_pkg::ERR_W-1:0]  rsp_error_code
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   localparam int AW = ets_pkg::NODE_AW;
   localparam int NC = ets_pkg::NODE_COUNT;

   // control
   logic state_ff, state_in;
   logic req_accept;
   logic exec_done;

   // held transaction
   logic [ets_pkg::KIND_W-1:0] kind_ff;
   logic [ets_pkg::NODE_W-1:0] src_ff;
   logic [ets_pkg::NODE_W-1:0] dst_ff;
   logic                       row_vld_ff;
   logic                       inf_vld_ff;

   // valid flags: a clear bit means the row or node still holds its reset value
   logic [NC-1:0] row_valid_ff, row_valid_in;
   logic [NC-1:0] inf_valid_ff, inf_valid_in;

   // memory ports
   logic [ets_pkg::ROW_W-1:0] row_rdata;
   logic [ets_pkg::ROW_W-1:0] row_cur;
   logic [ets_pkg::ROW_W-1:0] row_new;
   logic [ets_pkg::ROW_W-1:0] row_wdata;
   logic [AW-1:0]             row_addr;
   logic                      row_we;
   logic [0:0]                inf_rdata;
   logic [AW-1:0]             inf_rd_addr;
   logic                      inf_we;
   logic [AW-1:0]             src_idx;
   logic [AW-1:0]             dst_idx;

   logic                       cur_infected;
   logic [ets_pkg::MARK_W-1:0] cur_mark;
   ets_pkg::upd_type           upd;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ets_pkg::ACT_W-1:0] rsp_action_ff;
   logic [ets_pkg::ERR_W-1:0] rsp_error_code_ff;

   // ---------------------------------------------------------------- handshake
   assign req_stall  = (state_ff == ST_EXEC);
   assign req_accept = req_valid && !req_stall;
   // finish only when the response register is free or being emptied
   assign exec_done  = (state_ff == ST_EXEC) && !(rsp_valid_ff && rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (exec_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (exec_done) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // ---------------------------------------------------------------- memory reads
   // Read the source row and the relevant node flag as the transaction is accepted.
   assign inf_rd_addr = (req_kind == ets_pkg::KIND_RECOVER) ? req_dst_node[AW-1:0]
                                                            : req_src_node[AW-1:0];

   ets_ram #(
      .WIDTH (ets_pkg::ROW_W),
      .DEPTH (NC)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (row_we),
      .wr_addr (row_addr),
      .wr_data (row_wdata),
      .rd_en   (req_accept),
      .rd_addr (req_src_node[AW-1:0]),
      .rd_data (row_rdata)
   );

   ets_ram #(
      .WIDTH (1),
      .DEPTH (NC)
   ) u_inf_ram (
      .clock   (clock),
      .wr_en   (inf_we),
      .wr_addr (dst_idx),
      .wr_data (upd.inf_val),
      .rd_en   (req_accept),
      .rd_addr (inf_rd_addr),
      .rd_data (inf_rdata)
   );

   // ---------------------------------------------------------------- execute
   assign src_idx = src_ff[AW-1:0];
   assign dst_idx = dst_ff[AW-1:0];

   // invalid entries read as their reset value
   assign row_cur      = row_vld_ff ? row_rdata : '0;
   assign cur_infected = inf_vld_ff && inf_rdata[0];
   assign cur_mark     = row_cur[dst_idx * ets_pkg::MARK_W +: ets_pkg::MARK_W];

   ets_rules u_rules (
      .kind         (kind_ff),
      .src_node     (src_ff),
      .dst_node     (dst_ff),
      .src_infected (cur_infected),
      .mark         (cur_mark),
      .upd          (upd)
   );

   // merge the new mark into the row, or drop the whole row on recovery
   always_comb begin
      row_new = row_cur;
      row_new[dst_idx * ets_pkg::MARK_W +: ets_pkg::MARK_W] = upd.mark_val;
   end

   assign row_we    = exec_done && (upd.mark_we || upd.row_clear);
   assign row_addr  = upd.row_clear ? dst_idx : src_idx;
   assign row_wdata = upd.row_clear ? '0 : row_new;
   assign inf_we    = exec_done && upd.inf_we;

   always_comb begin
      row_valid_in = row_valid_ff;
      inf_valid_in = inf_valid_ff;
      if (row_we) begin
         row_valid_in[row_addr] = 1'b1;
      end
      if (inf_we) begin
         inf_valid_in[dst_idx] = 1'b1;
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_valid_ff <= '0;
         inf_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_valid_ff <= row_valid_in;
         inf_valid_ff <= inf_valid_in;
      end
   end

   // payload: hold the transaction and snapshot its valid flags alongside the reads
   always_ff @(posedge clock) begin
      if (req_accept) begin
         kind_ff    <= req_kind;
         src_ff     <= req_src_node;
         dst_ff     <= req_dst_node;
         row_vld_ff <= row_valid_ff[req_src_node[AW-1:0]];
         inf_vld_ff <= inf_valid_ff[inf_rd_addr];
      end
      if (exec_done) begin
         rsp_action_ff     <= upd.action;
         rsp_error_code_ff <= upd.error_code;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action     = rsp_action_ff;
   assign rsp_error_code = rsp_error_code_ff;

   // ---------------------------------------------------------------- assertions
   // memories are written only while a transaction finishes
   a_write_in_exec: assert property (@(posedge clock) disable iff (reset)
      (row_we || inf_we) |-> (state_ff == ST_EXEC && exec_done))
      else $error("memory write outside execute stage");

   // a finished transaction always shows up on the response channel
   a_done_to_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_done |=> rsp_valid)
      else $error("finished transaction did not produce a response");

   // every error response carries no action
   a_err_no_action: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_error_code != ets_pkg::ERR_OK) |-> (rsp_action == ets_pkg::ACT_NONE))
      else $error("error response with an action");

   // a written row is marked valid from then on
   a_row_valid_set: assert property (@(posedge clock) disable iff (reset)
      row_we |=> row_valid_ff[$past(row_addr)])
      else $error("row written without setting its valid flag");

endmodule

// ===== test/edge_transmission_state_table_unit_test.sv =====
// Self-checking testbench for edge_transmission_state_table_unit.
// Uses ets_pkg for widths and codes and holds its own model of the node flags and edge marks.
// A directed table runs first, then random bursts of epidemic and network events.
`timescale 1ns / 100ps

module edge_transmission_state_table_unit_test;

   localparam int RANDOM_EVENTS = 950;
   localparam int IDLE_PERCENT  = 36;
   localparam int LIMIT_NS      = 2_000_000;
   localparam int MAX_PRINTED   = 100;
   localparam int TAIL_CYCLES   = 8;
   localparam int NODES         = ets_pkg::NODE_COUNT;
   localparam int KW            = ets_pkg::KIND_W;
   localparam int NW            = ets_pkg::NODE_W;
   localparam int AW            = ets_pkg::ACT_W;
   localparam int EW            = ets_pkg::ERR_W;
   localparam int MW            = ets_pkg::MARK_W;

   // One row of stimulus; when typed is set, act and err hold the expected response.
   typedef struct packed {
      logic [KW-1:0] kind;
      logic [NW-1:0] src;
      logic [NW-1:0] dst;
      logic          typed;
      logic [AW-1:0] act;
      logic [EW-1:0] err;
   } event_row_type;

   // Expected response, tagged with the event that caused it.
   typedef struct packed {
      logic [KW-1:0] kind;
      logic [NW-1:0] src;
      logic [NW-1:0] dst;
      logic [AW-1:0] action;
      logic [EW-1:0] error_code;
   } outcome_type;

   localparam int DIRECTED_LEN = 27;
   localparam event_row_type DIRECTED_ROWS [DIRECTED_LEN] = '{
      // fresh table: every node healthy, every mark admissible
      '{ets_pkg::KIND_CONTACT,     6'd0,  6'd0,  1'b1, ets_pkg::ACT_RECORD, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_EDGE_ADD,    6'd0,  6'd63, 1'b1, ets_pkg::ACT_RECORD, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_EDGE_REMOVE, 6'd63, 6'd0,  1'b1, ets_pkg::ACT_RECORD, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_INFECT,      6'd0,  6'd63, 1'b1, ets_pkg::ACT_NONE,
        ets_pkg::ERR_NOT_INFECTED},
      '{ets_pkg::KIND_RECOVER,     6'd0,  6'd63, 1'b1, ets_pkg::ACT_NONE, ets_pkg::ERR_HEALTHY},
      // outside infection ignores the source field
      '{ets_pkg::KIND_OUTSIDE,     6'd63, 6'd63, 1'b1, ets_pkg::ACT_ACCEPT, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_INFECT,      6'd63, 6'd0,  1'b1, ets_pkg::ACT_ACCEPT, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_INFECT,      6'd63, 6'd0,  1'b1, ets_pkg::ACT_NONE,
        ets_pkg::ERR_TRANSMITTED},
      '{ets_pkg::KIND_EDGE_REMOVE, 6'd63, 6'd42, 1'b1, ets_pkg::ACT_RECORD, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_EDGE_REMOVE, 6'd63, 6'd42, 1'b1, ets_pkg::ACT_NONE,
        ets_pkg::ERR_DUP_REMOVE},
      '{ets_pkg::KIND_INFECT,      6'd63, 6'd42, 1'b1, ets_pkg::ACT_BLOCK, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_EDGE_ADD,    6'd63, 6'd21, 1'b1, ets_pkg::ACT_ACTIVATE, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_CONTACT,     6'd63, 6'd21, 1'b1, ets_pkg::ACT_CONTACT, ets_pkg::ERR_OK},
      // masked, unmasked and transmitted marks under network events
      '{ets_pkg::KIND_EDGE_REMOVE, 6'd63, 6'd21, 1'b0, ets_pkg::ACT_NONE, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_CONTACT,     6'd63, 6'd21, 1'b0, ets_pkg::ACT_NONE, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_EDGE_ADD,    6'd63, 6'd21, 1'b0, ets_pkg::ACT_NONE, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_EDGE_ADD,    6'd63, 6'd0,  1'b0, ets_pkg::ACT_NONE, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_CONTACT,     6'd63, 6'd0,  1'b0, ets_pkg::ACT_NONE, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_EDGE_REMOVE, 6'd63, 6'd0,  1'b0, ets_pkg::ACT_NONE, ets_pkg::ERR_OK},
      // unknown kinds are ignored
      '{3'd6,                      6'd63, 6'd63, 1'b1, ets_pkg::ACT_NONE, ets_pkg::ERR_OK},
      '{3'd7,                      6'd0,  6'd0,  1'b1, ets_pkg::ACT_NONE, ets_pkg::ERR_OK},
      // reinfection, then recovery clears the row
      '{ets_pkg::KIND_OUTSIDE,     6'd0,  6'd0,  1'b0, ets_pkg::ACT_NONE, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_RECOVER,     6'd0,  6'd63, 1'b0, ets_pkg::ACT_NONE, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_INFECT,      6'd63, 6'd0,  1'b0, ets_pkg::ACT_NONE, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_OUTSIDE,     6'd21, 6'd63, 1'b0, ets_pkg::ACT_NONE, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_INFECT,      6'd63, 6'd0,  1'b0, ets_pkg::ACT_NONE, ets_pkg::ERR_OK},
      '{ets_pkg::KIND_INFECT,      6'd0,  6'd63, 1'b0, ets_pkg::ACT_NONE, ets_pkg::ERR_OK}
   };

   // Well-formed epidemic burst on one edge; steps are dropped at random.
   localparam int BURST_LEN = 9;
   localparam logic [KW-1:0] BURST_KINDS [BURST_LEN] = '{
      ets_pkg::KIND_OUTSIDE, ets_pkg::KIND_EDGE_ADD, ets_pkg::KIND_EDGE_REMOVE,
      ets_pkg::KIND_CONTACT, ets_pkg::KIND_INFECT, ets_pkg::KIND_INFECT,
      ets_pkg::KIND_INFECT, ets_pkg::KIND_CONTACT, ets_pkg::KIND_RECOVER
   };

   logic            clock;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   logic [KW-1:0]   req_kind     = '0;
   logic [NW-1:0]   req_src_node = '0;
   logic [NW-1:0]   req_dst_node = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   logic [AW-1:0]   rsp_action;
   logic [EW-1:0]   rsp_error_code;

   // Model state: one infected flag per node, one mark per directed edge.
   logic            infected_flags [NODES];
   logic [MW-1:0]   mark_table     [NODES][NODES];

   outcome_type     pending_outcomes [$];
   bit              quiet_stretch = 1'b0;
   int              mismatch_count = 0;
   int              random_sent = 0;
   int              responses_seen = 0;
   int              accepted_seen = 0;
   int              blocked_seen = 0;
   int              errors_seen = 0;

   edge_transmission_state_table_unit u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_src_node   (req_src_node),
      .req_dst_node   (req_dst_node),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_action     (rsp_action),
      .rsp_error_code (rsp_error_code)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Apply one event to the model and return the response it must produce.
   function automatic outcome_type apply_epidemic_event(input logic [KW-1:0] kind,
                                                        input logic [NW-1:0] src,
                                                        input logic [NW-1:0] dst);
      outcome_type   res;
      logic [MW-1:0] mark;
      logic          src_infected;
      int            col;
      res.kind       = kind;
      res.src        = src;
      res.dst        = dst;
      res.action     = ets_pkg::ACT_NONE;
      res.error_code = ets_pkg::ERR_OK;
      // events naming a node past the network size are ignored
      if (int'(dst) < NODES && (kind > ets_pkg::KIND_INFECT || int'(src) < NODES)) begin
         mark         = mark_table[src][dst];
         src_infected = infected_flags[src];
         case (kind)
            ets_pkg::KIND_EDGE_ADD: begin
               res.action = ets_pkg::ACT_RECORD;
               if (src_infected && mark == ets_pkg::MARK_ADMISSIBLE) begin
                  res.action = ets_pkg::ACT_ACTIVATE;
               end else if (src_infected && mark == ets_pkg::MARK_MASKED) begin
                  mark_table[src][dst] = ets_pkg::MARK_ADMISSIBLE;
               end
            end
            ets_pkg::KIND_EDGE_REMOVE: begin
               res.action = ets_pkg::ACT_RECORD;
               if (src_infected && mark == ets_pkg::MARK_ADMISSIBLE) begin
                  mark_table[src][dst] = ets_pkg::MARK_MASKED;
               end else if (src_infected && mark == ets_pkg::MARK_MASKED) begin
                  res.action     = ets_pkg::ACT_NONE;
                  res.error_code = ets_pkg::ERR_DUP_REMOVE;
               end
            end
            ets_pkg::KIND_CONTACT: begin
               res.action = (src_infected && mark == ets_pkg::MARK_ADMISSIBLE)
                            ? ets_pkg::ACT_CONTACT : ets_pkg::ACT_RECORD;
            end
            ets_pkg::KIND_INFECT: begin
               if (!src_infected) begin
                  res.error_code = ets_pkg::ERR_NOT_INFECTED;
               end else if (mark == ets_pkg::MARK_ADMISSIBLE) begin
                  mark_table[src][dst] = ets_pkg::MARK_TRANSMITTED;
                  infected_flags[dst]  = 1'b1;
                  res.action           = ets_pkg::ACT_ACCEPT;
               end else if (mark == ets_pkg::MARK_MASKED) begin
                  mark_table[src][dst] = ets_pkg::MARK_ADMISSIBLE;
                  res.action           = ets_pkg::ACT_BLOCK;
               end else begin
                  res.error_code = ets_pkg::ERR_TRANSMITTED;
               end
            end
            ets_pkg::KIND_OUTSIDE: begin
               infected_flags[dst] = 1'b1;
               res.action          = ets_pkg::ACT_ACCEPT;
            end
            ets_pkg::KIND_RECOVER: begin
               if (!infected_flags[dst]) begin
                  res.error_code = ets_pkg::ERR_HEALTHY;
               end else begin
                  for (col = 0; col < NODES; col++) begin
                     mark_table[dst][col] = ets_pkg::MARK_ADMISSIBLE;
                  end
                  infected_flags[dst] = 1'b0;
                  res.action          = ets_pkg::ACT_RECORD;
               end
            end
            default: ;
         endcase
      end
      return res;
   endfunction

   // Bias node picks toward a few nodes so marks and flags get revisited.
   function automatic logic [NW-1:0] pick_node();
      if ($urandom_range(99) < 85) begin
         return NW'($urandom_range(7));
      end
      return NW'($urandom_range(NODES - 1));
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("%0t mismatch: %s", $realtime, what);
      end
   endtask

   // Drive one event at the falling edge, hold it until the transaction completes,
   // then queue the response it must produce.
   task automatic send_event(input event_row_type row);
      outcome_type predicted;
      @(negedge clock);
      // idle the request channel at random, except in the quiet stretch
      while (!quiet_stretch && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_kind     <= row.kind;
      req_src_node <= row.src;
      req_dst_node <= row.dst;
      @(posedge clock);
      while (req_stall !== 1'b0) begin
         @(posedge clock);
      end
      // advance the model on every event; typed rows override its answer
      predicted = apply_epidemic_event(row.kind, row.src, row.dst);
      if (row.typed) begin
         predicted.action     = row.act;
         predicted.error_code = row.err;
      end
      pending_outcomes.push_back(predicted);
   endtask

   // Stall the response channel at random, with the same quiet stretch.
   always @(negedge clock) begin
      rsp_stall <= !quiet_stretch && ($urandom_range(99) < IDLE_PERCENT);
   end

   // Check every completed response transaction against the oldest expectation.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("response with none expected: action %0d error %0d",
                                      rsp_action, rsp_error_code));
         end else begin
            want = pending_outcomes.pop_front();
            responses_seen++;
            if (want.action == ets_pkg::ACT_ACCEPT) accepted_seen++;
            if (want.action == ets_pkg::ACT_BLOCK) blocked_seen++;
            if (want.error_code != ets_pkg::ERR_OK) errors_seen++;
            if (rsp_action !== want.action) begin
               report_mismatch($sformatf("kind %0d %0d->%0d: action %0d, expected %0d",
                                         want.kind, want.src, want.dst,
                                         rsp_action, want.action));
            end
            if (rsp_error_code !== want.error_code) begin
               report_mismatch($sformatf("kind %0d %0d->%0d: error %0d, expected %0d",
                                         want.kind, want.src, want.dst,
                                         rsp_error_code, want.error_code));
            end
         end
      end
   end

   initial begin
      event_row_type burst [$];
      event_row_type row;
      logic [NW-1:0] s_node;
      logic [NW-1:0] t_node;
      int            i;
      int            k;

      // the model starts like the block after reset
      for (i = 0; i < NODES; i++) begin
         infected_flags[i] = 1'b0;
         for (k = 0; k < NODES; k++) begin
            mark_table[i][k] = ets_pkg::MARK_ADMISSIBLE;
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (i = 0; i < DIRECTED_LEN; i++) begin
         send_event(DIRECTED_ROWS[i]);
      end

      // random part: mostly well-formed bursts on one edge, the rest single noise events
      while (random_sent < RANDOM_EVENTS) begin
         burst.delete();
         if ($urandom_range(99) < 60) begin
            s_node = pick_node();
            t_node = pick_node();
            for (k = 0; k < BURST_LEN; k++) begin
               if ($urandom_range(99) < 15) continue;
               row.kind  = BURST_KINDS[k];
               row.typed = 1'b0;
               row.act   = ets_pkg::ACT_NONE;
               row.err   = ets_pkg::ERR_OK;
               row.src   = s_node;
               row.dst   = t_node;
               if (row.kind == ets_pkg::KIND_OUTSIDE) begin
                  row.src = NW'($urandom_range(NODES - 1));
                  row.dst = s_node;
               end else if (row.kind == ets_pkg::KIND_RECOVER) begin
                  row.src = NW'($urandom_range(NODES - 1));
                  row.dst = $urandom_range(1) ? s_node : t_node;
               end
               burst.push_back(row);
            end
         end else begin
            row.kind  = ($urandom_range(99) < 10) ? KW'($urandom_range(7, 6))
                                                  : KW'($urandom_range(5));
            row.src   = pick_node();
            row.dst   = pick_node();
            row.typed = 1'b0;
            row.act   = ets_pkg::ACT_NONE;
            row.err   = ets_pkg::ERR_OK;
            burst.push_back(row);
         end
         foreach (burst[j]) begin
            send_event(burst[j]);
            if (burst[j].kind <= ets_pkg::KIND_RECOVER) random_sent++;
            // hold both channels free of idling for one long stretch
            quiet_stretch = (random_sent >= 350 && random_sent < 520);
         end
      end

      @(negedge clock);
      req_valid <= 1'b0;

      // drain, then wait out a tail to catch stray responses
      while (pending_outcomes.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d directed and %0d random events, %0d responses checked",
               DIRECTED_LEN, random_sent, responses_seen);
      $display("infections accepted %0d, blocked %0d, error responses %0d, mismatches %0d",
               accepted_seen, blocked_seen, errors_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Watchdog: stop a hung run.
   initial begin
      #(LIMIT_NS);
      $display("timeout with %0d responses outstanding", pending_outcomes.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule
